@@ sv/icnsrle_pkg.sv @@
`timescale 1ns / 1ps

package icnsrle_pkg;

  // Configuration port
  localparam int unsigned CFG_W      = 21;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_ALPHA = 1'd1;

  localparam logic [CFG_W-1:0] PIXEL_COUNT_RST = 21'd1024;

  // Header decode
  localparam logic [7:0] REPEAT_BIAS = 8'd125;

  // Planes
  localparam logic [1:0] PLANE_ALPHA = 2'd0;
  localparam logic [1:0] PLANE_RED   = 2'd1;
  localparam logic [1:0] PLANE_BLUE  = 2'd3;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_SHORT    = 2'd2,
    ST_TRAILING = 2'd3
  } status_t;

endpackage

@@ sv/icnsrle_if.sv @@
`timescale 1ns / 1ps

interface icnsrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface icnsrle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] plane;
  logic [7:0] pixel_value;
  logic [7:0] run_length;
  logic       plane_complete;
  logic       stream_done;
  logic [1:0] status;

  modport source (output valid, output plane, output pixel_value, output run_length,
                  output plane_complete, output stream_done, output status,
                  input ready);
  modport sink   (input valid, input plane, input pixel_value, input run_length,
                  input plane_complete, input stream_done, input status,
                  output ready);
endinterface

@@ sv/icns_planar_rle_decoder.sv @@
`timescale 1ns / 1ps

// Planar run-length decoder for compressed icon streams.
// in_ch carries one compressed byte per request, with last_byte marking the
// end of the stream. out_ch carries run descriptors: plane, pixel value, run
// length, plane-complete flag, done flag and status. Planes are decoded in
// order alpha (when include_alpha is set), red, green, blue.
// Header bytes produce no result; each repeat value or literal byte produces
// one run; errors stop decoding and produce a status-only result (a stream
// ending short on a data byte flags that byte's run instead), after which
// bytes are taken and dropped until reset or a register write. Throughput:
// one byte per cycle while the output is not stalled. The header decode and
// counter update sit between the input handshake and the output register, so
// a result appears in the cycle after its byte is taken. When the receiver
// stalls the output register holds its request, and a new byte is taken only
// once that register is free or being drained in the same cycle.
// Reset (synchronous, rst_n low) loads pixel_count 1024, include_alpha 0 and
// restarts at the first plane; any register write also restarts decoding.
module icns_planar_rle_decoder #(
  parameter int unsigned MAX_PIXEL_COUNT = 1048576
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [icnsrle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icnsrle_pkg::CFG_W-1:0]       cfg_wdata,
  icnsrle_in_if.sink                          in_ch,
  icnsrle_out_if.source                       out_ch
);

  localparam int unsigned PIX_W = $clog2(MAX_PIXEL_COUNT + 1);
  localparam logic [icnsrle_pkg::CFG_W-1:0] MAX_C = icnsrle_pkg::CFG_W'(MAX_PIXEL_COUNT);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  // Configuration and decode state
  logic [icnsrle_pkg::CFG_W-1:0] pixel_count_r, pixel_count_nxt;
  logic                          include_alpha_r, include_alpha_nxt;
  phase_t                        phase_r, phase_nxt;
  logic [7:0]                    run_rem_r, run_rem_nxt;
  logic [PIX_W-1:0]              pix_left_r, pix_left_nxt;
  logic [1:0]                    plane_r, plane_nxt;
  logic                          stopped_r, stopped_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_plane_r, out_plane_nxt;
  logic [7:0]            out_value_r, out_value_nxt;
  logic [7:0]            out_run_r, out_run_nxt;
  logic                  out_pc_r, out_pc_nxt;
  logic                  out_done_r, out_done_nxt;
  icnsrle_pkg::status_t  out_status_r, out_status_nxt;

  logic                          accept;
  logic                          emit;
  logic [icnsrle_pkg::CFG_W-1:0] size_raw;
  logic [PIX_W-1:0]              plane_size;
  logic [7:0]                    hdr_len;
  logic [7:0]                    run;
  logic [PIX_W-1:0]              pix_after;
  logic [7:0]                    rem_after;
  logic                          last_done;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Clamp the current pixel count to 1..MAX_PIXEL_COUNT
  always_comb begin
    size_raw = pixel_count_r;
    if (size_raw == '0) begin
      size_raw = icnsrle_pkg::CFG_W'(1);
    end else if (size_raw > MAX_C) begin
      size_raw = MAX_C;
    end
    plane_size = PIX_W'(size_raw);
  end

  // Header length: repeat count or literal count
  assign hdr_len = in_ch.data_byte[7] ? (in_ch.data_byte - icnsrle_pkg::REPEAT_BIAS)
                                      : (in_ch.data_byte + 8'd1);

  // Run of this data byte, bounded by what the plane and the group allow
  always_comb begin
    run = (phase_r == PH_REPEAT) ? run_rem_r : 8'd1;
    if (icnsrle_pkg::CFG_W'(run) > icnsrle_pkg::CFG_W'(pix_left_r)) begin
      run = 8'(pix_left_r);
    end
    if (run > run_rem_r) begin
      run = run_rem_r;
    end
    pix_after = pix_left_r - PIX_W'(run);
    rem_after = run_rem_r - run;
  end

  // Decode one byte
  always_comb begin
    phase_nxt      = phase_r;
    run_rem_nxt    = run_rem_r;
    pix_left_nxt   = pix_left_r;
    plane_nxt      = plane_r;
    stopped_nxt    = stopped_r;
    emit           = 1'b0;
    last_done      = 1'b0;
    out_plane_nxt  = plane_r;
    out_value_nxt  = '0;
    out_run_nxt    = '0;
    out_pc_nxt     = 1'b0;
    out_done_nxt   = 1'b1;
    out_status_nxt = icnsrle_pkg::ST_OK;

    if (accept && !stopped_r) begin
      case (phase_r)
        PH_DONE: begin
          stopped_nxt    = 1'b1;
          emit           = 1'b1;
          out_status_nxt = icnsrle_pkg::ST_TRAILING;
        end
        PH_HEADER: begin
          if (in_ch.last_byte) begin
            stopped_nxt    = 1'b1;
            emit           = 1'b1;
            out_status_nxt = icnsrle_pkg::ST_SHORT;
          end else if (icnsrle_pkg::CFG_W'(hdr_len) > icnsrle_pkg::CFG_W'(pix_left_r)) begin
            stopped_nxt    = 1'b1;
            emit           = 1'b1;
            out_status_nxt = icnsrle_pkg::ST_OVERFLOW;
          end else begin
            phase_nxt   = in_ch.data_byte[7] ? PH_REPEAT : PH_LITERAL;
            run_rem_nxt = hdr_len;
          end
        end
        default: begin
          emit          = 1'b1;
          out_value_nxt = in_ch.data_byte;
          out_run_nxt   = run;
          out_done_nxt  = 1'b0;
          pix_left_nxt  = pix_after;
          run_rem_nxt   = rem_after;
          if (rem_after == '0) begin
            phase_nxt = PH_HEADER;
          end
          if (pix_after == '0) begin
            out_pc_nxt = 1'b1;
            if (plane_r == icnsrle_pkg::PLANE_BLUE) begin
              if (in_ch.last_byte) begin
                last_done    = 1'b1;
                out_done_nxt = 1'b1;
                stopped_nxt  = 1'b1;
              end else begin
                phase_nxt = PH_DONE;
              end
            end else begin
              plane_nxt    = plane_r + 2'd1;
              pix_left_nxt = plane_size;
              phase_nxt    = PH_HEADER;
              run_rem_nxt  = '0;
            end
          end
          // Stream ended with planes still open
          if (in_ch.last_byte && !last_done) begin
            out_done_nxt   = 1'b1;
            out_status_nxt = icnsrle_pkg::ST_SHORT;
            stopped_nxt    = 1'b1;
          end
        end
      endcase
    end
  end

  // Register writes and output handshake
  always_comb begin
    pixel_count_nxt   = pixel_count_r;
    include_alpha_nxt = include_alpha_r;
    if (cfg_we) begin
      case (cfg_index)
        icnsrle_pkg::REG_PIXEL_COUNT:   pixel_count_nxt   = cfg_wdata;
        icnsrle_pkg::REG_INCLUDE_ALPHA: include_alpha_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
    out_valid_nxt = emit || (out_valid_r && !out_ch.ready);
  end

  // Restart state computed from the incoming register values
  logic [icnsrle_pkg::CFG_W-1:0] rst_size_raw;
  logic [PIX_W-1:0]              rst_size;

  always_comb begin
    rst_size_raw = pixel_count_nxt;
    if (rst_size_raw == '0) begin
      rst_size_raw = icnsrle_pkg::CFG_W'(1);
    end else if (rst_size_raw > MAX_C) begin
      rst_size_raw = MAX_C;
    end
    rst_size = PIX_W'(rst_size_raw);
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r   <= icnsrle_pkg::PIXEL_COUNT_RST;
      include_alpha_r <= 1'b0;
      phase_r         <= PH_HEADER;
      run_rem_r       <= '0;
      pix_left_r      <= PIX_W'(icnsrle_pkg::PIXEL_COUNT_RST > MAX_C ? MAX_C
                                : icnsrle_pkg::PIXEL_COUNT_RST);
      plane_r         <= icnsrle_pkg::PLANE_RED;
      stopped_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else if (cfg_we) begin
      pixel_count_r   <= pixel_count_nxt;
      include_alpha_r <= include_alpha_nxt;
      phase_r         <= PH_HEADER;
      run_rem_r       <= '0;
      pix_left_r      <= rst_size;
      plane_r         <= include_alpha_nxt ? icnsrle_pkg::PLANE_ALPHA
                                           : icnsrle_pkg::PLANE_RED;
      stopped_r       <= 1'b0;
      out_valid_r     <= out_valid_nxt;
    end else begin
      phase_r     <= phase_nxt;
      run_rem_r   <= run_rem_nxt;
      pix_left_r  <= pix_left_nxt;
      plane_r     <= plane_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_plane_r  <= out_plane_nxt;
      out_value_r  <= out_value_nxt;
      out_run_r    <= out_run_nxt;
      out_pc_r     <= out_pc_nxt;
      out_done_r   <= out_done_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.plane          = out_plane_r;
  assign out_ch.pixel_value    = out_value_r;
  assign out_ch.run_length     = out_run_r;
  assign out_ch.plane_complete = out_pc_r;
  assign out_ch.stream_done    = out_done_r;
  assign out_ch.status         = out_status_r;

endmodule

@@ sv/icnsrle_checker.sv @@
`timescale 1ns / 1ps

module icnsrle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] plane,
  input logic [7:0] pixel_value,
  input logic [7:0] run_length,
  input logic       plane_complete,
  input logic       stream_done,
  input logic [1:0] status
);

  // Hold a stalled result request
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(run_length) && $stable(status)
      && $stable(pixel_value) && $stable(plane))
    else $error("stalled result changed");

  // Any error status ends the stream
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != icnsrle_pkg::ST_OK |-> stream_done)
    else $error("error status without stream_done");

  // Status-only results carry an error and no pixels
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && run_length == 8'd0 |->
      status != icnsrle_pkg::ST_OK && !plane_complete && pixel_value == 8'd0)
    else $error("malformed status-only result");

  // Trailing bytes are only reported after the blue plane
  a_trailing_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == icnsrle_pkg::ST_TRAILING |-> plane == icnsrle_pkg::PLANE_BLUE)
    else $error("trailing status outside blue plane");

endmodule

bind icns_planar_rle_decoder icnsrle_checker u_icnsrle_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .plane          (out_ch.plane),
  .pixel_value    (out_ch.pixel_value),
  .run_length     (out_ch.run_length),
  .plane_complete (out_ch.plane_complete),
  .stream_done    (out_ch.stream_done),
  .status         (out_ch.status)
);
